// ----- sv/sitdc_pkg.sv -----
package sitdc_pkg;

  localparam int VALUE_IN_W = 32;
  localparam int CHAR_W     = 8;
  localparam int RUN_W      = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Decimal digits of 2^w - 1: floor(w * log10(2)) + 1, log10(2) ~ 1233/4096
  function automatic int num_digits(input int w);
    return ((w * 1233) >> 12) + 1;
  endfunction

endpackage

// ----- sv/signed_int_to_decimal_chars.sv -----
// Signed integer to decimal ASCII text.
// Input channel: in_valid_i / in_stall_o with value_i, one request per value.
// Output channel: out_valid_o / out_stall_i with character_o, run_length_o
// and last_o, one request per character: a sign mark ('-' or space), then
// the magnitude digits, most significant first, no leading zeros.
// run_length_o carries the whole run length on every character; last_o
// marks the final one. The most negative value prints its true magnitude.
// A two-entry queue holds accepted values ahead of the converter, which runs
// a shift-and-add-3 pass, one magnitude bit per cycle. Characters leave one
// per cycle from an output register while out_stall_i is low and overlap the
// conversion of the next value, so the converter sets the sustained rate.
// An accepted request passes through the queue, the converter's shift pass
// and the emitter before its first character reaches the output register.
// out_stall_i holds the output register; the converter then holds its
// result and the queue fills, after which in_stall_o rises.
// Reset empties the queue and drops any run in progress; no clearing pass.
module signed_int_to_decimal_chars #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [sitdc_pkg::VALUE_IN_W-1:0]    value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [sitdc_pkg::CHAR_W-1:0]        character_o,
  output logic [sitdc_pkg::RUN_W-1:0]         run_length_o,
  output logic                                last_o
);

  localparam int BCD_W = 4 * sitdc_pkg::num_digits(VALUE_WIDTH);

  logic                   q_avail, q_pop, q_neg;
  logic [VALUE_WIDTH-1:0] q_mag;
  logic                   c_done, c_take, c_neg;
  logic [BCD_W-1:0]       c_bcd;

  sitdc_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .value_i (value_i),
    .pop_i   (q_pop),
    .avail_o (q_avail),
    .neg_o   (q_neg),
    .mag_o   (q_mag)
  );

  sitdc_conv #(.VALUE_WIDTH(VALUE_WIDTH)) u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (q_avail),
    .pop_o   (q_pop),
    .neg_i   (q_neg),
    .mag_i   (q_mag),
    .done_o  (c_done),
    .take_i  (c_take),
    .neg_o   (c_neg),
    .bcd_o   (c_bcd)
  );

  sitdc_emit #(.VALUE_WIDTH(VALUE_WIDTH)) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .done_i       (c_done),
    .take_o       (c_take),
    .neg_i        (c_neg),
    .bcd_i        (c_bcd),
    .valid_o      (out_valid_o),
    .stall_i      (out_stall_i),
    .character_o  (character_o),
    .run_length_o (run_length_o),
    .last_o       (last_o)
  );

endmodule

// ----- sv/sitdc_front.sv -----
module sitdc_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           stall_o,
  input  logic [sitdc_pkg::VALUE_IN_W-1:0] value_i,
  input  logic                           pop_i,
  output logic                           avail_o,
  output logic                           neg_o,
  output logic [VALUE_WIDTH-1:0]         mag_o
);

  logic [1:0]             cnt_q, cnt_d;
  logic                   wptr_q, rptr_q;
  logic                   neg_q [2];
  logic [VALUE_WIDTH-1:0] mag_q [2];

  logic [VALUE_WIDTH+sitdc_pkg::VALUE_IN_W-1:0] wide;
  logic [VALUE_WIDTH-1:0] v;
  logic                   v_neg;
  logic [VALUE_WIDTH-1:0] v_mag;
  logic                   push;

  // zero-extend or truncate the request value to the working width
  assign wide  = {VALUE_WIDTH'(0), value_i};
  assign v     = wide[VALUE_WIDTH-1:0];
  assign v_neg = v[VALUE_WIDTH-1];
  assign v_mag = v_neg ? (~v + VALUE_WIDTH'(1)) : v;

  assign stall_o = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign push    = valid_i && !stall_o;
  assign neg_o   = neg_q[rptr_q];
  assign mag_o   = mag_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      neg_q[wptr_q] <= v_neg;
      mag_q[wptr_q] <= v_mag;
    end
  end

endmodule

// ----- sv/sitdc_conv.sv -----
module sitdc_conv #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     avail_i,
  output logic                     pop_o,
  input  logic                     neg_i,
  input  logic [VALUE_WIDTH-1:0]   mag_i,
  output logic                     done_o,
  input  logic                     take_i,
  output logic                     neg_o,
  output logic [4*sitdc_pkg::num_digits(VALUE_WIDTH)-1:0] bcd_o
);

  localparam int NDIG  = sitdc_pkg::num_digits(VALUE_WIDTH);
  localparam int BCD_W = 4 * NDIG;
  localparam int CW    = $clog2(VALUE_WIDTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [CW-1:0]          bitcnt_q;
  logic [VALUE_WIDTH-1:0] sh_q;
  logic [BCD_W-1:0]       bcd_q;
  logic [BCD_W-1:0]       adj;
  logic                   neg_q;

  assign pop_o  = (state_q == ST_IDLE) && avail_i;
  assign done_o = (state_q == ST_DONE);
  assign neg_o  = neg_q;
  assign bcd_o  = bcd_q;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (avail_i) begin
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (bitcnt_q == CW'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      bitcnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        bitcnt_q <= CW'(VALUE_WIDTH);
      end else if (state_q == ST_BUSY) begin
        bitcnt_q <= bitcnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sh_q  <= mag_i;
      bcd_q <= '0;
      neg_q <= neg_i;
    end else if (state_q == ST_BUSY) begin
      bcd_q <= {adj[BCD_W-2:0], sh_q[VALUE_WIDTH-1]};
      sh_q  <= {sh_q[VALUE_WIDTH-2:0], 1'b0};
    end
  end

endmodule

// ----- sv/sitdc_emit.sv -----
module sitdc_emit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 done_i,
  output logic                                 take_o,
  input  logic                                 neg_i,
  input  logic [4*sitdc_pkg::num_digits(VALUE_WIDTH)-1:0] bcd_i,
  output logic                                 valid_o,
  input  logic                                 stall_i,
  output logic [sitdc_pkg::CHAR_W-1:0]         character_o,
  output logic [sitdc_pkg::RUN_W-1:0]          run_length_o,
  output logic                                 last_o
);

  localparam int NDIG  = sitdc_pkg::num_digits(VALUE_WIDTH);
  localparam int BCD_W = 4 * NDIG;
  localparam int NW    = $clog2(NDIG + 2);
  localparam int DIW   = $clog2(NDIG);

  logic                          active_q;
  logic                          out_valid_q;
  logic [NW-1:0]                 k_q, nd_q;
  logic                          neg_q;
  logic [BCD_W-1:0]              dig_q;
  logic [sitdc_pkg::CHAR_W-1:0]  char_q;
  logic [sitdc_pkg::RUN_W-1:0]   run_q;
  logic                          last_q;

  logic                          adv;
  logic                          at_last;
  logic [NW-1:0]                 nd_new;
  logic [NW-1:0]                 total;
  logic [DIW-1:0]                idx;
  logic [3:0]                    dig;
  logic [sitdc_pkg::CHAR_W-1:0]  ch;

  assign adv     = !out_valid_q || !stall_i;
  assign at_last = (k_q == nd_q);
  assign take_o  = done_i && (!active_q || (adv && at_last));
  assign total   = nd_q + NW'(1);
  assign idx     = DIW'(nd_q - k_q);
  assign dig     = dig_q[{idx, 2'b00} +: 4];
  assign ch      = (k_q == '0) ? (neg_q ? sitdc_pkg::CHAR_MINUS : sitdc_pkg::CHAR_SPACE)
                               : sitdc_pkg::CHAR_ZERO + {4'b0000, dig};

  // digit count: highest nonzero digit, at least one
  always_comb begin
    nd_new = NW'(1);
    for (int i = 1; i < NDIG; i++) begin
      if (bcd_i[4*i +: 4] != 4'd0) begin
        nd_new = NW'(i + 1);
      end
    end
  end

  assign valid_o      = out_valid_q;
  assign character_o  = char_q;
  assign run_length_o = run_q;
  assign last_o       = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      if (adv) begin
        out_valid_q <= active_q;
      end
      // a new run overrides the drop of the finished one
      if (take_o) begin
        active_q <= 1'b1;
        k_q      <= '0;
      end else if (adv && active_q) begin
        k_q <= k_q + NW'(1);
        if (at_last) begin
          active_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && active_q) begin
      char_q <= ch;
      run_q  <= sitdc_pkg::RUN_W'(total);
      last_q <= at_last;
    end
    if (take_o) begin
      neg_q <= neg_i;
      dig_q <= bcd_i;
      nd_q  <= nd_new;
    end
  end

endmodule

// ----- bench/tb_signed_int_to_decimal_chars.sv -----
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_chars;

  localparam int CLK_PERIOD   = 20;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_DIGITS   = 20;

  typedef struct {
    logic [sitdc_pkg::CHAR_W-1:0] character;
    logic [sitdc_pkg::RUN_W-1:0]  run_length;
    logic                         last;
  } char_rec_t;

  logic                             clk_i     = 1'b0;
  logic                             rst_ni    = 1'b0;
  logic                             in_valid  = 1'b0;
  logic [sitdc_pkg::VALUE_IN_W-1:0] in_value  = '0;
  logic                             out_stall = 1'b0;
  logic                             in_stall;
  logic                             out_valid;
  logic [sitdc_pkg::CHAR_W-1:0]     out_char;
  logic [sitdc_pkg::RUN_W-1:0]      out_run_length;
  logic                             out_last;

  char_rec_t expected_chars[$];
  int        error_count    = 0;
  int        cycle_count    = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;

  signed_int_to_decimal_chars #(
    .VALUE_WIDTH(sitdc_pkg::VALUE_IN_W)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .value_i     (in_value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .character_o (out_char),
    .run_length_o(out_run_length),
    .last_o      (out_last)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Expected text of one value: sign mark, then digits most significant first
  function automatic void queue_decimal_text(input logic [sitdc_pkg::VALUE_IN_W-1:0] v);
    logic [sitdc_pkg::VALUE_IN_W-1:0] mag;
    logic [3:0]                       digs[MAX_DIGITS];
    logic [sitdc_pkg::RUN_W-1:0]      run_len;
    char_rec_t                        rec;
    int                               nd;
    mag = v[sitdc_pkg::VALUE_IN_W-1] ? -v : v;
    nd = 0;
    do begin
      digs[nd] = 4'(mag % 10);
      mag = mag / 10;
      nd++;
    end while (mag != 0);
    run_len = sitdc_pkg::RUN_W'(nd + 1);
    rec.character  = v[sitdc_pkg::VALUE_IN_W-1] ? sitdc_pkg::CHAR_MINUS
                                                : sitdc_pkg::CHAR_SPACE;
    rec.run_length = run_len;
    rec.last       = 1'b0;
    expected_chars.push_back(rec);
    for (int k = nd - 1; k >= 0; k--) begin
      rec.character  = sitdc_pkg::CHAR_ZERO + sitdc_pkg::CHAR_W'(digs[k]);
      rec.run_length = run_len;
      rec.last       = (k == 0);
      expected_chars.push_back(rec);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall) begin
      queue_decimal_text(in_value);
    end
  end

  always @(posedge clk_i) begin
    char_rec_t exp_rec;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character: actual %h", out_char);
        error_count++;
      end else begin
        exp_rec = expected_chars.pop_front();
        if (out_char !== exp_rec.character) begin
          $error("character: expected %h, actual %h", exp_rec.character, out_char);
          error_count++;
        end
        if (out_run_length !== exp_rec.run_length) begin
          $error("run_length: expected %0d, actual %0d", exp_rec.run_length,
                 out_run_length);
          error_count++;
        end
        if (out_last !== exp_rec.last) begin
          $error("last: expected %b, actual %b", exp_rec.last, out_last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Leave valid high on return so back-to-back requests need no re-raise
  task automatic send_value(input logic [sitdc_pkg::VALUE_IN_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Magnitude of a chosen digit count, random sign
  function automatic logic [sitdc_pkg::VALUE_IN_W-1:0] value_by_digits();
    longint lo;
    longint hi;
    longint mag;
    int     nd;
    nd = $urandom_range(1, 10);
    lo = (nd == 1) ? 0 : 1;
    for (int k = 1; k < nd; k++) lo = lo * 10;
    hi = (nd == 1) ? 9 : lo * 10 - 1;
    if (hi > 64'd2147483648) hi = 64'd2147483648;
    mag = lo + (longint'($urandom) % (hi - lo + 1));
    if ($urandom_range(1) == 1) mag = -mag;
    return mag[sitdc_pkg::VALUE_IN_W-1:0];
  endfunction

  task automatic test_directed();
    int dir_values[$];
    dir_values = {0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -98765,
                  1234567890, -1234567890, 999999999, -999999999, 1000000000,
                  -1000000000, 2147483647, -2147483647, int'(32'h8000_0000)};
    send_idle_pct  = 33;
    recv_stall_pct = 33;
    foreach (dir_values[i]) send_value(dir_values[i]);
  endtask

  task automatic test_random_with_gaps();
    send_idle_pct  = 33;
    recv_stall_pct = 33;
    repeat (60) begin
      if ($urandom_range(1) == 1) send_value(value_by_digits());
      else send_value($urandom);
    end
  endtask

  task automatic test_back_to_back();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (30) begin
      if ($urandom_range(1) == 1) send_value(value_by_digits());
      else send_value($urandom);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_with_gaps();
    test_back_to_back();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
